// ===== design/spd_pkg.sv =====
// ---------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the serial packet deframer.
// ---------------------------------------------------------------------------
package spd_pkg;

  localparam logic [7:0] Hdr1Byte = 8'h54;
  localparam logic [7:0] Hdr2Byte = 8'hFE;
  localparam logic [7:0] TypeByte = 8'd31;

  // Payload buffer depth, from 2 to 64 entries.
  localparam int unsigned BufDepth = 64;

  localparam int unsigned StoreIdxW = 6;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 24;

  localparam logic [2:0] CodeHdr1 = 3'd0;
  localparam logic [2:0] CodeHdr2 = 3'd1;
  localparam logic [2:0] CodeType = 3'd2;
  localparam logic [2:0] CodeLen  = 3'd3;
  localparam logic [2:0] CodePay  = 3'd4;

  typedef enum logic [4:0] {
    StHdr1 = 5'b00001,
    StHdr2 = 5'b00010,
    StType = 5'b00100,
    StLen  = 5'b01000,
    StPay  = 5'b10000
  } state_e;

  typedef struct packed {
    state_e     state;
    logic [7:0] sum;
    logic [7:0] length;
    logic [7:0] count;
    logic       bank;
  } ctx_t;

  typedef struct packed {
    logic [2:0]           parse_state;
    logic                 store_valid;
    logic [7:0]           store_byte;
    logic [StoreIdxW-1:0] store_index;
    logic                 store_bank;
    logic                 frame_done;
    logic                 frame_good;
    logic                 frame_bank;
    logic                 overflow;
  } result_t;

  function automatic logic [2:0] state_code(input state_e st);
    logic [2:0] code;
    unique case (st)
      StHdr1:  code = CodeHdr1;
      StHdr2:  code = CodeHdr2;
      StType:  code = CodeType;
      StLen:   code = CodeLen;
      StPay:   code = CodePay;
      default: code = CodeHdr1;
    endcase
    return code;
  endfunction

endpackage

// ===== design/spd_parser.sv =====
// ---------------------------------------------------------------------------
// spd_parser
// Next-state and result logic of the deframer for one received byte.
// ---------------------------------------------------------------------------
module spd_parser (
  input  spd_pkg::ctx_t    ctx_i,
  input  logic [7:0]       rx_byte_i,
  output spd_pkg::ctx_t    ctx_o,
  output spd_pkg::result_t res_o
);

  logic [7:0] last_idx;
  logic       in_buffer;

  assign last_idx  = ctx_i.length - 8'd1;
  assign in_buffer = {1'b0, ctx_i.count} < 9'(spd_pkg::BufDepth);

  always_comb begin
    ctx_o = ctx_i;
    res_o = '0;
    unique case (ctx_i.state)
      spd_pkg::StHdr1: begin
        if (rx_byte_i == spd_pkg::Hdr1Byte) begin
          ctx_o.state = spd_pkg::StHdr2;
        end
      end
      spd_pkg::StHdr2: begin
        if (rx_byte_i == spd_pkg::Hdr2Byte) begin
          ctx_o.state = spd_pkg::StType;
        end
      end
      spd_pkg::StType: begin
        if (rx_byte_i == spd_pkg::TypeByte) begin
          ctx_o.sum   = '0;
          ctx_o.state = spd_pkg::StLen;
        end
      end
      spd_pkg::StLen: begin
        ctx_o.length = rx_byte_i;
        ctx_o.count  = '0;
        ctx_o.state  = spd_pkg::StPay;
      end
      spd_pkg::StPay: begin
        if (ctx_i.count == last_idx) begin
          res_o.frame_done = 1'b1;
          res_o.frame_good = (ctx_i.sum == rx_byte_i);
          res_o.frame_bank = ctx_i.bank;
          ctx_o.bank       = ~ctx_i.bank;
          ctx_o.state      = spd_pkg::StHdr1;
        end else begin
          if (in_buffer) begin
            res_o.store_valid = 1'b1;
            res_o.store_byte  = rx_byte_i;
            res_o.store_index = ctx_i.count[spd_pkg::StoreIdxW-1:0];
            res_o.store_bank  = ctx_i.bank;
          end else begin
            res_o.overflow = 1'b1;
          end
          ctx_o.count = ctx_i.count + 8'd1;
          ctx_o.sum   = ctx_i.sum + rx_byte_i;
        end
      end
      default: begin
      end
    endcase
    res_o.parse_state = spd_pkg::state_code(ctx_o.state);
  end

endmodule

// ===== design/serial_packet_deframer_core.sv =====
// ---------------------------------------------------------------------------
// serial_packet_deframer_core
// Finds 0x54 0xFE 31 L frames in a byte stream and reports payload writes.
// ---------------------------------------------------------------------------
// One byte enters per word on the slave stream. Every accepted byte gives
// exactly one result word on the master stream, in the cycle after acceptance.
// The result carries the parser state after the byte, a payload write
// (byte, index and bank) and, on the checksum byte, the frame verdict; the
// checksum byte is also marked with tlast.
// Throughput is one byte per cycle while the master stream takes each result:
// the state update is a single pass of compare and 8-bit add logic between
// the state registers and the result register.
// When the receiver stalls, the held result stays in the result register and
// s_axis_tready_o drops until the word is taken; no byte is lost.
// Reset puts the parser in the first-header state, clears the sum, length,
// count and bank registers and the valid flag; result data is not reset.
// ---------------------------------------------------------------------------
module serial_packet_deframer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [7:0] rx_byte
  input  logic [spd_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [2:0] parse_state, [3] store_valid, [11:4] store_byte,
  // [17:12] store_index, [18] store_bank, [19] frame_good,
  // [20] frame_bank, [21] overflow, [23:22] zero
  output logic [spd_pkg::OutDataW-1:0] m_axis_tdata_o,
  // frame_done
  output logic                         m_axis_tlast_o
);

  spd_pkg::ctx_t    ctx_q, ctx_d;
  spd_pkg::result_t res_q, res_d;
  logic             out_valid_q;
  logic             in_fire;

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  spd_parser u_parser (
    .ctx_i     (ctx_q),
    .rx_byte_i (s_axis_tdata_i[7:0]),
    .ctx_o     (ctx_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.state  <= spd_pkg::StHdr1;
      ctx_q.sum    <= '0;
      ctx_q.length <= '0;
      ctx_q.count  <= '0;
      ctx_q.bank   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        ctx_q <= ctx_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = res_q.frame_done;
  assign m_axis_tdata_o  = {2'b00, res_q.overflow, res_q.frame_bank, res_q.frame_good,
                            res_q.store_bank, res_q.store_index, res_q.store_byte,
                            res_q.store_valid, res_q.parse_state};

  a_store_in_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.store_valid |-> res_q.parse_state == spd_pkg::CodePay)
    else $error("payload write reported outside the payload state");

  a_done_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_done |->
      !res_q.store_valid && !res_q.overflow && res_q.parse_state == spd_pkg::CodeHdr1)
    else $error("frame end mixed with a payload write or wrong state");

  a_overflow_no_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.overflow |-> !res_q.store_valid)
    else $error("dropped byte also reported as written");

  a_bank_flip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.bank != $past(ctx_q.bank) |-> out_valid_q && res_q.frame_done)
    else $error("bank changed without a frame end");

endmodule
